// ===== rtl/tild_pkg.sv =====
// Shared constants, codes and types for the tty input line discipline.
`default_nettype none

package tild_pkg;

   // Ring geometry
   localparam int RING_DEPTH = 128;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CUR_W      = PTR_W + 1;
   localparam int SUM_W      = ((CUR_W > 8) ? CUR_W : 8) + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int MODE_W     = 2;
   localparam int OPT_W      = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OPTION_FLAGS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_CHARS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDIT_CHARS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EOF_FULL_CHARS = 3'd4;

   localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CBREAK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COOKED = 2'd2;

   // Option flag bit positions
   localparam int OPT_CRLF       = 0;
   localparam int OPT_FLOW       = 1;
   localparam int OPT_ECHO       = 2;
   localparam int OPT_VISUAL     = 3;
   localparam int OPT_ECHO_CRLF  = 4;
   localparam int OPT_ERASE_BACK = 5;
   localparam int OPT_KILL       = 6;
   localparam int OPT_ERASE      = 7;
   localparam int OPT_EOF        = 8;

   // Register reset values
   localparam logic [MODE_W-1:0] RST_INPUT_MODE     = MODE_COOKED;
   localparam logic [OPT_W-1:0]  RST_OPTION_FLAGS   = 9'h1FF;
   localparam logic [15:0]       RST_FLOW_CHARS     = 16'h1113;
   localparam logic [23:0]       RST_EDIT_CHARS     = 24'h15087F;
   localparam logic [15:0]       RST_EOF_FULL_CHARS = 16'h0407;

   // Character codes
   localparam logic [7:0] CH_BS   = 8'h08;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_UP   = 8'h5E;
   localparam logic [7:0] CH_DEL  = 8'h7F;
   localparam logic [7:0] VIS_OFS = 8'h40;

   // Echo work handed from the decision stage to the echo stage
   localparam logic [2:0] ECHO_NONE  = 3'd0;
   localparam logic [2:0] ECHO_CHAR  = 3'd1;
   localparam logic [2:0] ECHO_BELL  = 3'd2;
   localparam logic [2:0] ECHO_KILL  = 3'd3;
   localparam logic [2:0] ECHO_ERASE = 3'd4;
   localparam logic [2:0] ECHO_START = 3'd5;

   localparam int MAX_ECHO = 6;
   localparam int CNT_W    = 3;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] echo_char;
      logic [7:0] release_count;
      logic       output_held;
   } tild_desc_type;

   function automatic logic is_ctl(input logic [7:0] c);
      return (c < CH_SP) || (c == CH_DEL);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tild_ifs.sv =====
// Request and response channel interfaces for the tty input line discipline.
`default_nettype none

interface tild_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] chars_available;

   modport source (output valid, output rx_byte, output chars_available, input ready);
   modport sink   (input valid, input rx_byte, input chars_available, output ready);
endinterface

interface tild_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic [7:0] release_count;
   logic       output_held;
   logic       kick_output;
   logic       last;

   modport source (output valid, output echo_valid, output echo_byte, output release_count,
                   output output_held, output kick_output, output last, input ready);
   modport sink   (input valid, input echo_valid, input echo_byte, input release_count,
                   input output_held, input kick_output, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/tild_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module tild_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tild_echo.sv =====
// Echo stage: expands one decided item into its echo bytes and plays out the results.
`default_nettype none

module tild_echo import tild_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             ready,
   input  tild_desc_type    desc,
   input  logic [7:0]       ram_rdata,
   input  logic [OPT_W-1:0] opts,
   tild_rsp_if.source       rsp
);

   logic          slot_valid_ff;
   tild_desc_type slot_ff;

   logic             out_valid_ff;
   logic [7:0]       out_bytes_ff [MAX_ECHO];
   logic [CNT_W-1:0] out_cnt_ff;
   logic [CNT_W-1:0] out_idx_ff;
   logic             out_echo_ff;
   logic [7:0]       out_rel_ff;
   logic             out_held_ff;
   logic             out_kick_ff;

   logic [7:0]       exp_bytes [MAX_ECHO];
   logic [CNT_W-1:0] exp_n;
   logic             out_last;
   logic             out_free;
   logic             slot_move;
   logic [7:0]       c;

   assign c = slot_ff.echo_char;

   // Expand the waiting item into its echo bytes; the erased byte comes from the RAM
   always_comb begin
      exp_n = '0;
      for (int k = 0; k < MAX_ECHO; k++) begin
         exp_bytes[k] = 8'h00;
      end
      case (slot_ff.kind)
         ECHO_CHAR: begin
            if (((c == CH_LF) || (c == CH_CR)) && opts[OPT_ECHO_CRLF]) begin
               exp_bytes[0] = CH_CR;
               exp_bytes[1] = CH_LF;
               exp_n        = CNT_W'(2);
            end else if (is_ctl(c) && opts[OPT_VISUAL]) begin
               exp_bytes[0] = CH_UP;
               exp_bytes[1] = c + VIS_OFS;
               exp_n        = CNT_W'(2);
            end else begin
               exp_bytes[0] = c;
               exp_n        = CNT_W'(1);
            end
         end
         ECHO_BELL: begin
            exp_bytes[0] = c;
            exp_n        = CNT_W'(1);
         end
         ECHO_KILL: begin
            exp_bytes[0] = CH_CR;
            exp_bytes[1] = CH_LF;
            exp_n        = CNT_W'(2);
         end
         ECHO_ERASE: begin
            if (opts[OPT_ERASE_BACK]) begin
               exp_bytes[0] = CH_BS;
               exp_bytes[1] = CH_SP;
               exp_bytes[2] = CH_BS;
               exp_bytes[3] = CH_BS;
               exp_bytes[4] = CH_SP;
               exp_bytes[5] = CH_BS;
               exp_n = (is_ctl(ram_rdata) && opts[OPT_VISUAL]) ? CNT_W'(6) : CNT_W'(3);
            end else begin
               exp_bytes[0] = CH_BS;
               exp_bytes[1] = CH_BS;
               exp_n = (is_ctl(ram_rdata) && opts[OPT_VISUAL]) ? CNT_W'(2) : CNT_W'(1);
            end
         end
         default: begin
            exp_n = '0;
         end
      endcase
   end

   // Handshake between the slot and the output stage
   assign out_last  = (out_idx_ff == out_cnt_ff - CNT_W'(1));
   assign out_free  = !out_valid_ff || (rsp.ready && out_last);
   assign slot_move = slot_valid_ff && out_free;
   assign ready     = !slot_valid_ff || out_free;

   // Hold one decided item until the output stage frees
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (push) begin
         slot_valid_ff <= 1'b1;
      end else if (slot_move) begin
         slot_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff <= desc;
      end
   end

   // Load the output stage, then advance one result per taken handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else if (slot_move) begin
         out_valid_ff <= 1'b1;
         out_idx_ff   <= '0;
      end else if (out_valid_ff && rsp.ready) begin
         if (out_last) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_idx_ff <= out_idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_move) begin
         for (int k = 0; k < MAX_ECHO; k++) begin
            out_bytes_ff[k] <= exp_bytes[k];
         end
         out_cnt_ff  <= (exp_n == '0) ? CNT_W'(1) : exp_n;
         out_echo_ff <= (exp_n != '0);
         out_rel_ff  <= slot_ff.release_count;
         out_held_ff <= slot_ff.output_held;
         out_kick_ff <= (exp_n != '0) || (slot_ff.kind == ECHO_START);
      end
   end

   // Drive the response channel
   assign rsp.valid         = out_valid_ff;
   assign rsp.echo_valid    = out_echo_ff;
   assign rsp.echo_byte     = out_bytes_ff[out_idx_ff];
   assign rsp.release_count = out_rel_ff;
   assign rsp.output_held   = out_held_ff;
   assign rsp.kick_output   = out_kick_ff;
   assign rsp.last          = out_last;

endmodule

`default_nettype wire

// ===== rtl/tty_input_line_discipline_core.sv =====
// Top level of the tty input line discipline: configuration, ring state and decision.
//
//   channel  direction  handshake          payload
//   req_ch   in         valid/ready        rx_byte, chars_available
//   rsp_ch   out        valid/ready        echo_valid, echo_byte, release_count,
//                                          output_held, kick_output, last
//   csr_*    in         csr_we (no wait)   csr_index, csr_wdata
//
// An item is decided in its accept cycle: ring tail, line cursor and flow hold are updated
// and the ring RAM is written (store) or read (erase) on that edge.
// An item's results leave through the echo slot register and then the output register; an item
// yields max(1, echo bytes) results, 1 to 6, one per cycle while rsp_ch.ready is high.
// A new item is taken while the previous one's results are still playing out.
// Reset clears the tail, cursor and hold flag and loads the register defaults; the ring
// RAM needs no clearing, since an entry is only read back after it was written.
`default_nettype none

module tty_input_line_discipline_core import tild_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tild_req_if.sink              req_ch,
   tild_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic [MODE_W-1:0] mode_ff;
   logic [OPT_W-1:0]  opts_ff;
   logic [15:0]       flow_ff;
   logic [23:0]       edit_ff;
   logic [15:0]       eof_full_ff;

   // Ring state
   logic [PTR_W-1:0] tail_ff,   tail_in;
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic             held_ff,   held_in;

   logic             accept;
   logic             slot_ready;
   logic             do_store;
   logic             do_erase;
   logic [7:0]       ram_rdata;
   logic [PTR_W-1:0] tail_next;
   logic [PTR_W-1:0] tail_prev;
   logic [CUR_W-1:0] kill_tail;
   logic [7:0]       ch;
   logic [7:0]       ch2;
   logic [7:0]       start_c;
   logic [7:0]       stop_c;
   logic [7:0]       full_c;
   logic [SUM_W-1:0] avail_w;
   logic             room_raw;
   logic             full_cooked;
   logic             hit_kill;
   logic             hit_erase;
   logic             hit_eof;
   tild_desc_type    desc;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RST_INPUT_MODE;
         opts_ff     <= RST_OPTION_FLAGS;
         flow_ff     <= RST_FLOW_CHARS;
         edit_ff     <= RST_EDIT_CHARS;
         eof_full_ff <= RST_EOF_FULL_CHARS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INPUT_MODE:     mode_ff     <= csr_wdata[MODE_W-1:0];
            CSR_OPTION_FLAGS:   opts_ff     <= csr_wdata[OPT_W-1:0];
            CSR_FLOW_CHARS:     flow_ff     <= csr_wdata[15:0];
            CSR_EDIT_CHARS:     edit_ff     <= csr_wdata[23:0];
            CSR_EOF_FULL_CHARS: eof_full_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = slot_ready;

   // Ring pointer arithmetic, modulo the ring depth
   assign tail_next = (tail_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
   assign tail_prev = (tail_ff == '0) ? PTR_W'(RING_DEPTH - 1) : tail_ff - PTR_W'(1);
   assign kill_tail = (CUR_W'(tail_ff) >= cursor_ff)
                    ? CUR_W'(tail_ff) - cursor_ff
                    : CUR_W'(tail_ff) + CUR_W'(RING_DEPTH) - cursor_ff;

   // Input character classification
   assign ch      = req_ch.rx_byte;
   assign ch2     = ((ch == CH_CR) && opts_ff[OPT_CRLF]) ? CH_LF : ch;
   assign start_c = flow_ff[15:8];
   assign stop_c  = flow_ff[7:0];
   assign full_c  = eof_full_ff[7:0];
   assign avail_w = SUM_W'(req_ch.chars_available);

   assign room_raw    = avail_w < SUM_W'(RING_DEPTH);
   assign full_cooked = (avail_w + SUM_W'(cursor_ff)) >= SUM_W'(RING_DEPTH - 1);
   assign hit_kill    = (ch2 == edit_ff[23:16]) && opts_ff[OPT_KILL];
   assign hit_erase   = ((ch2 == edit_ff[15:8]) || (ch2 == edit_ff[7:0])) && opts_ff[OPT_ERASE];
   assign hit_eof     = (ch2 == eof_full_ff[15:8]) && opts_ff[OPT_EOF];

   // Decide the item: next ring state, RAM access and echo work
   always_comb begin
      tail_in            = tail_ff;
      cursor_in          = cursor_ff;
      held_in            = held_ff;
      do_store           = 1'b0;
      do_erase           = 1'b0;
      desc.kind          = ECHO_NONE;
      desc.echo_char     = ch2;
      desc.release_count = 8'h00;
      if (mode_ff == MODE_RAW) begin
         if (room_raw) begin
            do_store           = 1'b1;
            desc.release_count = 8'h01;
         end
      end else if (opts_ff[OPT_FLOW] && (ch2 == start_c)) begin
         held_in   = 1'b0;
         desc.kind = ECHO_START;
      end else if (opts_ff[OPT_FLOW] && (ch2 == stop_c)) begin
         held_in = 1'b1;
      end else begin
         held_in = 1'b0;
         if (mode_ff == MODE_CBREAK) begin
            if (!room_raw) begin
               desc.kind      = ECHO_BELL;
               desc.echo_char = full_c;
            end else begin
               do_store           = 1'b1;
               desc.release_count = 8'h01;
               if (opts_ff[OPT_ECHO]) begin
                  desc.kind = ECHO_CHAR;
               end
            end
         end else if (hit_kill) begin
            tail_in   = PTR_W'(kill_tail);
            cursor_in = '0;
            desc.kind = ECHO_KILL;
         end else if (hit_erase) begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - CUR_W'(1);
               tail_in   = tail_prev;
               do_erase  = 1'b1;
               if (opts_ff[OPT_ECHO]) begin
                  desc.kind = ECHO_ERASE;
               end
            end
         end else if ((ch2 == CH_LF) || (ch2 == CH_CR)) begin
            do_store           = 1'b1;
            desc.release_count = 8'(cursor_ff + CUR_W'(1));
            cursor_in          = '0;
            if (opts_ff[OPT_ECHO]) begin
               desc.kind = ECHO_CHAR;
            end
         end else if (full_cooked) begin
            desc.kind      = ECHO_BELL;
            desc.echo_char = full_c;
         end else if (hit_eof) begin
            if (opts_ff[OPT_ECHO]) begin
               desc.kind = ECHO_CHAR;
            end
            if (cursor_ff == '0) begin
               do_store           = 1'b1;
               desc.release_count = 8'h01;
            end
         end else begin
            if (opts_ff[OPT_ECHO]) begin
               desc.kind = ECHO_CHAR;
            end
            cursor_in = cursor_ff + CUR_W'(1);
            do_store  = 1'b1;
         end
      end
      if (do_store) begin
         tail_in = tail_next;
      end
      desc.output_held = held_in;
   end

   // Advance ring state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff   <= '0;
         cursor_ff <= '0;
         held_ff   <= 1'b0;
      end else if (accept) begin
         tail_ff   <= tail_in;
         cursor_ff <= cursor_in;
         held_ff   <= held_in;
      end
   end

   // Input ring: store at the tail, read back the byte being erased
   tild_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && do_store),
      .wr_addr (tail_ff),
      .wr_data (ch2),
      .rd_en   (accept && do_erase),
      .rd_addr (tail_prev),
      .rd_data (ram_rdata)
   );

   tild_echo u_echo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .ready     (slot_ready),
      .desc      (desc),
      .ram_rdata (ram_rdata),
      .opts      (opts_ff),
      .rsp       (rsp_ch)
   );

`ifndef SYNTHESIS
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CUR_W'(RING_DEPTH - 1))
      else $error("line cursor beyond ring depth");

   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(tail_ff) && $stable(cursor_ff))
      else $error("ring state moved without an accepted item");

   a_held_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(held_ff) |-> $past(accept) && ($past(mode_ff) != MODE_RAW))
      else $error("output hold set without a stop item");

   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(do_store && do_erase))
      else $error("store and erase on the same item");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_tty_input_line_discipline_core.sv =====
// Self-checking testbench for the tty input line discipline core.
`timescale 1ns / 1ps

module tb_tty_input_line_discipline_core import tild_pkg::*;;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PHASE_COUNT     = 9;
   localparam int OPENING_COUNT   = 22;

   // Unused fourth mode, handled as cooked
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic [7:0] release_count;
      logic       output_held;
      logic       kick_output;
      logic       last;
   } echo_result_type;

   // Predicts the echo run of each accepted byte and checks the block against it
   class echo_scoreboard;
      logic [7:0]       ring [RING_DEPTH];
      logic [PTR_W-1:0] tail;
      logic [7:0]       cursor;
      logic             held;
      logic [MODE_W-1:0] mode;
      logic [OPT_W-1:0] opts;
      logic [15:0]      flow;
      logic [23:0]      edit;
      logic [15:0]      eofc;
      logic [7:0]       echo_run [$];
      logic             kick_now;
      echo_result_type  expected_echo [$];
      int               faults;

      function new();
         faults = 0;
         reset_state();
      endfunction

      function void reset_state();
         foreach (ring[i]) ring[i] = 8'h00;
         tail   = '0;
         cursor = '0;
         held   = 1'b0;
         mode   = RST_INPUT_MODE;
         opts   = RST_OPTION_FLAGS;
         flow   = RST_FLOW_CHARS;
         edit   = RST_EDIT_CHARS;
         eofc   = RST_EOF_FULL_CHARS;
         expected_echo.delete();
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_INPUT_MODE:     mode = data[MODE_W-1:0];
            CSR_OPTION_FLAGS:   opts = data[OPT_W-1:0];
            CSR_FLOW_CHARS:     flow = data[15:0];
            CSR_EDIT_CHARS:     edit = data[23:0];
            CSR_EOF_FULL_CHARS: eofc = data[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_echo.size();
      endfunction

      function logic is_control(logic [7:0] c);
         return (c < CH_SP) || (c == CH_DEL);
      endfunction

      function void emit(logic [7:0] c);
         if (echo_run.size() < 8) echo_run.push_back(c);
         kick_now = 1'b1;
      endfunction

      // Echo one character: CR LF pair, caret form for control codes, or as is
      function void show_char(logic [7:0] c);
         logic [7:0] shown;
         if ((c == CH_LF || c == CH_CR) && opts[OPT_ECHO_CRLF]) begin
            emit(CH_CR);
            emit(CH_LF);
         end else if (is_control(c) && opts[OPT_VISUAL]) begin
            shown = c + VIS_OFS;
            emit(CH_UP);
            emit(shown);
         end else begin
            emit(c);
         end
      endfunction

      function void push_to_ring(logic [7:0] c);
         ring[tail] = c;
         tail = tail + PTR_W'(1);
      endfunction

      // Drop the newest character and rub it out on the echo side
      function void back_up();
         logic [7:0] c;
         tail = tail - PTR_W'(1);
         c = ring[tail];
         if (!opts[OPT_ECHO]) return;
         if (is_control(c) && opts[OPT_VISUAL]) begin
            emit(CH_BS);
            if (opts[OPT_ERASE_BACK]) begin
               emit(CH_SP);
               emit(CH_BS);
            end
         end
         emit(CH_BS);
         if (opts[OPT_ERASE_BACK]) begin
            emit(CH_SP);
            emit(CH_BS);
         end
      endfunction

      function void discipline_step(logic [7:0] rx, logic [7:0] avail, output logic [7:0] rel);
         logic [7:0] ch;
         ch  = rx;
         rel = '0;
         // Raw: store unless the readers hold a full ring
         if (mode == MODE_RAW) begin
            if (int'(avail) < RING_DEPTH) begin
               push_to_ring(ch);
               rel = 8'd1;
            end
            return;
         end
         if (ch == CH_CR && opts[OPT_CRLF]) ch = CH_LF;
         if (opts[OPT_FLOW]) begin
            if (ch == flow[15:8]) begin
               held = 1'b0;
               kick_now = 1'b1;
               return;
            end
            if (ch == flow[7:0]) begin
               held = 1'b1;
               return;
            end
         end
         held = 1'b0;
         if (mode == MODE_CBREAK) begin
            if (int'(avail) >= RING_DEPTH) begin
               emit(eofc[7:0]);
            end else begin
               push_to_ring(ch);
               if (opts[OPT_ECHO]) show_char(ch);
               rel = 8'd1;
            end
            return;
         end
         // Cooked (and the unused fourth mode)
         if (ch == edit[23:16] && opts[OPT_KILL]) begin
            tail = tail - cursor[PTR_W-1:0];
            cursor = '0;
            emit(CH_CR);
            emit(CH_LF);
            return;
         end
         if ((ch == edit[15:8] || ch == edit[7:0]) && opts[OPT_ERASE]) begin
            if (cursor != 8'd0) begin
               cursor = cursor - 8'd1;
               back_up();
            end
            return;
         end
         if (ch == CH_LF || ch == CH_CR) begin
            if (opts[OPT_ECHO]) show_char(ch);
            push_to_ring(ch);
            rel = cursor + 8'd1;
            cursor = '0;
            return;
         end
         if (int'(avail) + int'(cursor) >= RING_DEPTH - 1) begin
            emit(eofc[7:0]);
            return;
         end
         if (ch == eofc[15:8] && opts[OPT_EOF]) begin
            if (opts[OPT_ECHO]) show_char(ch);
            if (cursor != 8'd0) return;
            push_to_ring(ch);
            rel = 8'd1;
            return;
         end
         if (opts[OPT_ECHO]) show_char(ch);
         cursor = cursor + 8'd1;
         push_to_ring(ch);
      endfunction

      // Note an accepted byte and queue the results it should cause
      function void take_byte(logic [7:0] rx, logic [7:0] avail);
         logic [7:0]      rel;
         int              n;
         echo_result_type r;
         echo_run.delete();
         kick_now = 1'b0;
         discipline_step(rx, avail, rel);
         n = (echo_run.size() > 0) ? echo_run.size() : 1;
         for (int k = 0; k < n; k++) begin
            r.echo_valid    = echo_run.size() > 0;
            r.echo_byte     = (echo_run.size() > 0) ? echo_run[k] : 8'h00;
            r.release_count = rel;
            r.output_held   = held;
            r.kick_output   = kick_now;
            r.last          = (k == n - 1);
            expected_echo.push_back(r);
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
         end
      endfunction

      function void check_echo(echo_result_type got);
         echo_result_type want;
         if (expected_echo.size() == 0) begin
            $error("result with nothing pending: echo_byte 0x%0h", got.echo_byte);
            faults++;
            return;
         end
         want = expected_echo.pop_front();
         compare_field("echo_valid", 8'(want.echo_valid), 8'(got.echo_valid));
         compare_field("echo_byte", want.echo_byte, got.echo_byte);
         compare_field("release_count", want.release_count, got.release_count);
         compare_field("output_held", 8'(want.output_held), 8'(got.output_held));
         compare_field("kick_output", 8'(want.kick_output), 8'(got.kick_output));
         compare_field("last", 8'(want.last), 8'(got.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_idle_on;
   logic                  rsp_idle_on;
   logic                  hold_off_pending;
   int                    cycles;

   echo_scoreboard board = new();

   tild_req_if req_ch ();
   tild_rsp_if rsp_ch ();

   tty_input_line_discipline_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Opening items as {rx_byte, chars_available}, run under the reset settings
   logic [15:0] opening_items [OPENING_COUNT] = '{
      {8'h61, 8'd0},   // plain letter
      {8'h01, 8'd0},   // control code, caret echo
      {8'h80, 8'd0},   // high byte is printable
      {8'hFF, 8'd0},
      {8'h08, 8'd0},   // erase a printable byte
      {8'h7F, 8'd0},   // second erase character
      {8'h7F, 8'd0},   // erase a control code: longest run
      {8'h0D, 8'd5},   // CR mapped to LF, line released
      {8'h08, 8'd0},   // erase on empty line
      {8'h04, 8'd0},   // EOF at line start
      {8'h62, 8'd0},
      {8'h04, 8'd0},   // EOF mid-line: echo only
      {8'h15, 8'd0},   // line kill
      {8'h13, 8'd0},   // stop output
      {8'h63, 8'd0},   // any other byte lifts the hold
      {8'h13, 8'd0},
      {8'h11, 8'd0},   // start output
      {8'h0A, 8'd128}, // LF ahead of the full check
      {8'h64, 8'd127}, // ring full: bell
      {8'h65, 8'd128},
      {8'h00, 8'd64},  // NUL, caret echo
      {8'h0D, 8'd0}
   };

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Stop a hung run
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Accept results, check them, and throttle ready
   initial begin : result_sink
      int              hold_left;
      echo_result_type seen;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            seen.echo_valid    = rsp_ch.echo_valid;
            seen.echo_byte     = rsp_ch.echo_byte;
            seen.release_count = rsp_ch.release_count;
            seen.output_held   = rsp_ch.output_held;
            seen.kick_output   = rsp_ch.kick_output;
            seen.last          = rsp_ch.last;
            board.check_echo(seen);
         end
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_idle_on) begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= 33);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offer one item, with an occasional gap ahead of it, and wait for acceptance
   task automatic send_byte(input logic [7:0] rx, input logic [7:0] avail);
      if (req_idle_on && $urandom_range(0, 99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.rx_byte         <= rx;
      req_ch.chars_available <= avail;
      do @(posedge clock); while (!req_ch.ready);
      board.take_byte(rx, avail);
   endtask

   // Stop offering and wait until every pending result is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic load_settings(input logic [CSR_DATA_W-1:0] mode, input logic [CSR_DATA_W-1:0] opts,
                                input logic [CSR_DATA_W-1:0] flow, input logic [CSR_DATA_W-1:0] edit,
                                input logic [CSR_DATA_W-1:0] eofc);
      put_reg(CSR_INPUT_MODE, mode);
      put_reg(CSR_OPTION_FLAGS, opts);
      put_reg(CSR_FLOW_CHARS, flow);
      put_reg(CSR_EDIT_CHARS, edit);
      put_reg(CSR_EOF_FULL_CHARS, eofc);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly printable text, with line ends and the current editing characters mixed in
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 8'($urandom_range(8'h20, 8'h7E));
      if (roll < 65) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
         0: return CH_CR;
         1: return CH_LF;
         2: return board.edit[23:16];
         3: return board.edit[15:8];
         4: return board.edit[7:0];
         5: return board.eofc[15:8];
         6: return board.flow[15:8];
         default: return board.flow[7:0];
      endcase
   endfunction

   // Mostly a nearly empty ring, sometimes one close to full
   function automatic logic [7:0] pick_avail();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 8'($urandom_range(0, 8));
      if (roll < 90) return 8'($urandom_range(100, 128));
      return 8'($urandom_range(0, 128));
   endfunction

   // Stimulus: reset, opening items, then random phases under changing settings
   initial begin
      int items;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.rx_byte   <= '0;
      req_ch.chars_available <= '0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      hold_off_pending = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_items[i]) send_byte(opening_items[i][15:8], opening_items[i][7:0]);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         items = 16;
         case (p)
            0: load_settings(CSR_DATA_W'(MODE_RAW), CSR_DATA_W'($urandom_range(0, 511)),
                             CSR_DATA_W'($urandom_range(0, 65535)),
                             CSR_DATA_W'($urandom_range(0, 16777215)),
                             CSR_DATA_W'($urandom_range(0, 65535)));
            1: load_settings(CSR_DATA_W'(MODE_CBREAK), '0, CSR_DATA_W'(RST_FLOW_CHARS),
                             CSR_DATA_W'(RST_EDIT_CHARS), CSR_DATA_W'(RST_EOF_FULL_CHARS));
            2: load_settings(CSR_DATA_W'(MODE_CBREAK), CSR_DATA_W'(RST_OPTION_FLAGS),
                             CSR_DATA_W'($urandom_range(0, 65535)),
                             CSR_DATA_W'(RST_EDIT_CHARS), CSR_DATA_W'(RST_EOF_FULL_CHARS));
            3: begin
               // long stretch with no idling on either side
               req_idle_on = 1'b0;
               rsp_idle_on = 1'b0;
               items = 30;
               load_settings(CSR_DATA_W'(MODE_COOKED), CSR_DATA_W'(RST_OPTION_FLAGS),
                             CSR_DATA_W'(RST_FLOW_CHARS), CSR_DATA_W'(RST_EDIT_CHARS),
                             CSR_DATA_W'(RST_EOF_FULL_CHARS));
            end
            4: load_settings(CSR_DATA_W'(MODE_COOKED), CSR_DATA_W'($urandom_range(0, 511)),
                             CSR_DATA_W'(16'hFFFF), '0, '0);
            5: load_settings(CSR_DATA_W'(MODE_SPARE), CSR_DATA_W'($urandom_range(0, 511)),
                             '0, CSR_DATA_W'(24'hFFFFFF), CSR_DATA_W'(16'hFFFF));
            6: begin
               // receiver holds off while the sender keeps offering
               items = 40;
               load_settings(CSR_DATA_W'(MODE_COOKED), CSR_DATA_W'(RST_OPTION_FLAGS),
                             CSR_DATA_W'(RST_FLOW_CHARS), CSR_DATA_W'(RST_EDIT_CHARS),
                             CSR_DATA_W'(RST_EOF_FULL_CHARS));
               hold_off_pending = 1'b1;
            end
            7: load_settings(CSR_DATA_W'(MODE_COOKED), CSR_DATA_W'($urandom_range(0, 511)),
                             CSR_DATA_W'($urandom_range(0, 65535)),
                             CSR_DATA_W'($urandom_range(0, 16777215)),
                             CSR_DATA_W'($urandom_range(0, 65535)));
            default: load_settings(CSR_DATA_W'(MODE_RAW), '0,
                                   CSR_DATA_W'($urandom_range(0, 65535)),
                                   CSR_DATA_W'($urandom_range(0, 16777215)),
                                   CSR_DATA_W'($urandom_range(0, 65535)));
         endcase
         repeat (items) send_byte(pick_byte(), pick_avail());
         drain();
         req_idle_on = 1'b1;
         rsp_idle_on = 1'b1;
      end

      if (board.faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tild_pkg.sv
rtl/tild_ifs.sv
rtl/tild_ram.sv
rtl/tild_echo.sv
rtl/tty_input_line_discipline_core.sv
tb/tb_tty_input_line_discipline_core.sv
